// ----- design/sql_query_tokenizer_macros.svh -----
// Assertion macros for the tokenizer; empty in synthesis builds.
`ifndef SQL_QUERY_TOKENIZER_MACROS_SVH
`define SQL_QUERY_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define SQLT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sql_query_tokenizer assertion failed");
// Next-cycle implication
`define SQLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sql_query_tokenizer assertion failed");
`else
`define SQLT_ASSERT_NOW(label, clk, rst, ante, cons)
`define SQLT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/sqlt_pkg.sv -----
package sqlt_pkg;

   localparam int LENGTH_BITS_DEF   = 16;
   localparam int POSITION_BITS_DEF = 32;
   localparam int MAX_TOKENS        = 3;
   localparam int TOKEN_IDX_BITS    = 2;

   // Token classes
   localparam logic [4:0] C_ID      = 5'd0;
   localparam logic [4:0] C_COLID   = 5'd1;
   localparam logic [4:0] C_SPACE   = 5'd2;
   localparam logic [4:0] C_STAR    = 5'd3;
   localparam logic [4:0] C_LP      = 5'd4;
   localparam logic [4:0] C_RP      = 5'd5;
   localparam logic [4:0] C_PLUS    = 5'd6;
   localparam logic [4:0] C_REM     = 5'd7;
   localparam logic [4:0] C_COMMA   = 5'd8;
   localparam logic [4:0] C_BITAND  = 5'd9;
   localparam logic [4:0] C_BITNOT  = 5'd10;
   localparam logic [4:0] C_SEMI    = 5'd11;
   localparam logic [4:0] C_MINUS   = 5'd12;
   localparam logic [4:0] C_SLASH   = 5'd13;
   localparam logic [4:0] C_EQ      = 5'd14;
   localparam logic [4:0] C_LE      = 5'd15;
   localparam logic [4:0] C_NE      = 5'd16;
   localparam logic [4:0] C_LSHIFT  = 5'd17;
   localparam logic [4:0] C_LT      = 5'd18;
   localparam logic [4:0] C_GE      = 5'd19;
   localparam logic [4:0] C_RSHIFT  = 5'd20;
   localparam logic [4:0] C_GT      = 5'd21;
   localparam logic [4:0] C_BITOR   = 5'd22;
   localparam logic [4:0] C_CONCAT  = 5'd23;
   localparam logic [4:0] C_STRING  = 5'd24;
   localparam logic [4:0] C_DOT     = 5'd25;
   localparam logic [4:0] C_INTEGER = 5'd26;
   localparam logic [4:0] C_FLOAT   = 5'd27;
   localparam logic [4:0] C_BLOB    = 5'd28;
   localparam logic [4:0] C_ILLEGAL = 5'd29;
   localparam logic [4:0] C_END     = 5'd30;

   // Characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_REM    = 8'h25;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LP     = 8'h28;
   localparam logic [7:0] CH_RP     = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_UPX    = 8'h58;
   localparam logic [7:0] CH_UPE    = 8'h45;
   localparam logic [7:0] CH_LOWX   = 8'h78;
   localparam logic [7:0] CH_LOWE   = 8'h65;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   typedef enum logic [4:0] {
      M_IDLE, M_WORD, M_XSTART, M_SPACE, M_MINUS1, M_LINECMT, M_SLASH1,
      M_SLASHSTAR, M_BLK, M_BLKSTAR, M_EQ1, M_LT1, M_GT1, M_BANG1, M_BAR1,
      M_QUOTE, M_QDELIM, M_DOT1, M_INT, M_FRAC, M_EXPE, M_EXPSIGN, M_EXPDIG,
      M_ILLRUN, M_BLOBE, M_BLOBO
   } mode_type;

   // What a byte does when scanning starts fresh
   typedef struct packed {
      logic       emit;
      logic       open;
      mode_type   mode;
      logic [4:0] cls;
      logic       quote;
   } begin_type;

   // Output stage status seen by the input side
   typedef struct packed {
      logic free;
      logic valid;
   } stage_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == 8'h5F;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic begin_type begin_fn(input logic [7:0] c);
      begin_type b;
      b = '{emit: 1'b0, open: 1'b0, mode: M_IDLE, cls: C_ILLEGAL, quote: 1'b0};
      case (c)
         CH_STAR:   begin b.emit = 1'b1; b.cls = C_STAR;   end
         CH_LP:     begin b.emit = 1'b1; b.cls = C_LP;     end
         CH_RP:     begin b.emit = 1'b1; b.cls = C_RP;     end
         CH_PLUS:   begin b.emit = 1'b1; b.cls = C_PLUS;   end
         CH_REM:    begin b.emit = 1'b1; b.cls = C_REM;    end
         CH_COMMA:  begin b.emit = 1'b1; b.cls = C_COMMA;  end
         CH_AMP:    begin b.emit = 1'b1; b.cls = C_BITAND; end
         CH_TILDE:  begin b.emit = 1'b1; b.cls = C_BITNOT; end
         CH_SEMI:   begin b.emit = 1'b1; b.cls = C_SEMI;   end
         CH_MINUS:  begin b.open = 1'b1; b.mode = M_MINUS1; b.cls = C_MINUS;   end
         CH_SLASH:  begin b.open = 1'b1; b.mode = M_SLASH1; b.cls = C_SLASH;   end
         CH_EQ:     begin b.open = 1'b1; b.mode = M_EQ1;    b.cls = C_EQ;      end
         CH_LT:     begin b.open = 1'b1; b.mode = M_LT1;    b.cls = C_LT;      end
         CH_GT:     begin b.open = 1'b1; b.mode = M_GT1;    b.cls = C_GT;      end
         CH_BANG:   begin b.open = 1'b1; b.mode = M_BANG1;  b.cls = C_ILLEGAL; end
         CH_BAR:    begin b.open = 1'b1; b.mode = M_BAR1;   b.cls = C_BITOR;   end
         CH_DOT:    begin b.open = 1'b1; b.mode = M_DOT1;   b.cls = C_DOT;     end
         CH_SQUOTE, CH_DQUOTE: begin
            b.open = 1'b1; b.mode = M_QUOTE; b.cls = C_ILLEGAL; b.quote = 1'b1;
         end
         default: begin
            if (is_digit(c)) begin
               b.open = 1'b1; b.mode = M_INT; b.cls = C_INTEGER;
            end else if (c == CH_LOWX || c == CH_UPX) begin
               b.open = 1'b1; b.mode = M_XSTART; b.cls = C_ID;
            end else if (is_ident(c)) begin
               b.open = 1'b1; b.mode = M_WORD; b.cls = C_ID;
            end else if (is_space(c)) begin
               b.open = 1'b1; b.mode = M_SPACE; b.cls = C_SPACE;
            end else begin
               b.emit = 1'b1; b.cls = C_ILLEGAL;
            end
         end
      endcase
      return b;
   endfunction

endpackage

// ----- design/sqlt_scan.sv -----
// Scanner state and the one-step transition for a byte or end of text
module sqlt_scan #(
   parameter int LENGTH_BITS   = sqlt_pkg::LENGTH_BITS_DEF,
   parameter int POSITION_BITS = sqlt_pkg::POSITION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               text_byte,
   input  logic                     end_of_text,
   output logic [4:0]               tok_class [sqlt_pkg::MAX_TOKENS],
   output logic [POSITION_BITS-1:0] tok_start [sqlt_pkg::MAX_TOKENS],
   output logic [LENGTH_BITS-1:0]   tok_length [sqlt_pkg::MAX_TOKENS],
   output logic [sqlt_pkg::TOKEN_IDX_BITS-1:0] tok_count
);

   sqlt_pkg::mode_type       mode_ff, mode_in;
   logic [4:0]               cls_ff, cls_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0]   len_ff, len_in;
   logic                     minus_ff, minus_in;
   logic [7:0]               delim_ff, delim_in;
   logic                     aci_ff, aci_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   logic                     is_end;
   logic [LENGTH_BITS:0]     sum1, sum2;
   logic [LENGTH_BITS-1:0]   grown1, grown2;
   logic [POSITION_BITS-1:0] pos_m1;
   logic [4:0]               qclass;
   sqlt_pkg::begin_type      bg;
   sqlt_pkg::mode_type       eff_mode;
   logic                     redo;
   logic [sqlt_pkg::TOKEN_IDX_BITS-1:0] cnt;

   assign is_end = end_of_text || (text_byte == sqlt_pkg::CH_NUL);
   assign sum1   = {1'b0, len_ff} + {{LENGTH_BITS{1'b0}}, 1'b1};
   assign sum2   = {1'b0, len_ff} + {{(LENGTH_BITS-1){1'b0}}, 2'd2};
   // lengths saturate at all ones
   assign grown1 = sum1[LENGTH_BITS] ? '1 : sum1[LENGTH_BITS-1:0];
   assign grown2 = sum2[LENGTH_BITS] ? '1 : sum2[LENGTH_BITS-1:0];
   assign pos_m1 = pos_ff - {{(POSITION_BITS-1){1'b0}}, 1'b1};
   assign qclass = (delim_ff == sqlt_pkg::CH_SQUOTE) ? sqlt_pkg::C_STRING :
                   (aci_ff ? sqlt_pkg::C_ID : sqlt_pkg::C_ILLEGAL);
   assign bg     = sqlt_pkg::begin_fn(text_byte);
   // an x not followed by a quote is an ordinary word
   assign eff_mode = (mode_ff == sqlt_pkg::M_XSTART && text_byte != sqlt_pkg::CH_SQUOTE) ?
                     sqlt_pkg::M_WORD : mode_ff;

   // Transition: tokens out and next state
   always_comb begin
      mode_in  = mode_ff;
      cls_in   = cls_ff;
      start_in = start_ff;
      len_in   = len_ff;
      minus_in = minus_ff;
      delim_in = delim_ff;
      aci_in   = aci_ff;
      pos_in   = pos_ff;
      redo     = 1'b0;
      cnt      = '0;
      for (int i = 0; i < sqlt_pkg::MAX_TOKENS; i++) begin
         tok_class[i]  = '0;
         tok_start[i]  = '0;
         tok_length[i] = '0;
      end

      if (is_end) begin
         // flush what is pending, then the end marker
         case (mode_ff)
            sqlt_pkg::M_IDLE: begin
            end
            sqlt_pkg::M_SLASHSTAR: begin
               tok_class[cnt] = sqlt_pkg::C_SLASH; tok_start[cnt] = start_ff;
               tok_length[cnt] = {{(LENGTH_BITS-1){1'b0}}, 1'b1}; cnt = cnt + 2'd1;
               tok_class[cnt] = sqlt_pkg::C_STAR;
               tok_start[cnt] = start_ff + {{(POSITION_BITS-1){1'b0}}, 1'b1};
               tok_length[cnt] = {{(LENGTH_BITS-1){1'b0}}, 1'b1}; cnt = cnt + 2'd1;
            end
            sqlt_pkg::M_QDELIM: begin
               tok_class[cnt] = qclass; tok_start[cnt] = start_ff;
               tok_length[cnt] = len_ff; cnt = cnt + 2'd1;
            end
            sqlt_pkg::M_QUOTE, sqlt_pkg::M_EXPE, sqlt_pkg::M_BLOBE,
            sqlt_pkg::M_BLOBO: begin
               tok_class[cnt] = sqlt_pkg::C_ILLEGAL; tok_start[cnt] = start_ff;
               tok_length[cnt] = len_ff; cnt = cnt + 2'd1;
            end
            sqlt_pkg::M_EXPSIGN: begin
               tok_class[cnt] = sqlt_pkg::C_ILLEGAL; tok_start[cnt] = start_ff;
               tok_length[cnt] = len_ff; cnt = cnt + 2'd1;
               tok_class[cnt] = minus_ff ? sqlt_pkg::C_MINUS : sqlt_pkg::C_PLUS;
               tok_start[cnt] = pos_m1;
               tok_length[cnt] = {{(LENGTH_BITS-1){1'b0}}, 1'b1}; cnt = cnt + 2'd1;
            end
            default: begin
               tok_class[cnt] = cls_ff; tok_start[cnt] = start_ff;
               tok_length[cnt] = len_ff; cnt = cnt + 2'd1;
            end
         endcase
         tok_class[cnt] = sqlt_pkg::C_END; tok_start[cnt] = pos_ff;
         tok_length[cnt] = '0; cnt = cnt + 2'd1;
         mode_in  = sqlt_pkg::M_IDLE;
         cls_in   = '0;
         start_in = '0;
         len_in   = '0;
         minus_in = 1'b0;
         delim_in = '0;
         aci_in   = 1'b1;
      end else begin
         pos_in = pos_ff + {{(POSITION_BITS-1){1'b0}}, 1'b1};
         case (eff_mode)
            sqlt_pkg::M_IDLE: redo = 1'b1;
            sqlt_pkg::M_WORD: begin
               if (sqlt_pkg::is_ident(text_byte) || text_byte == sqlt_pkg::CH_AT ||
                   text_byte == sqlt_pkg::CH_HASH) begin
                  if (text_byte == sqlt_pkg::CH_AT || text_byte == sqlt_pkg::CH_HASH)
                     cls_in = sqlt_pkg::C_COLID;
                  mode_in = sqlt_pkg::M_WORD;
                  len_in  = grown1;
               end else redo = 1'b1;
            end
            sqlt_pkg::M_XSTART: begin
               mode_in = sqlt_pkg::M_BLOBE; cls_in = sqlt_pkg::C_BLOB; len_in = grown1;
            end
            sqlt_pkg::M_SPACE: begin
               if (sqlt_pkg::is_space(text_byte)) len_in = grown1;
               else redo = 1'b1;
            end
            sqlt_pkg::M_MINUS1: begin
               if (text_byte == sqlt_pkg::CH_MINUS) begin
                  mode_in = sqlt_pkg::M_LINECMT; cls_in = sqlt_pkg::C_SPACE;
                  len_in = grown1;
               end else redo = 1'b1;
            end
            sqlt_pkg::M_LINECMT: begin
               if (text_byte != sqlt_pkg::CH_LF) len_in = grown1;
               else redo = 1'b1;
            end
            sqlt_pkg::M_SLASH1: begin
               if (text_byte == sqlt_pkg::CH_STAR) begin
                  mode_in = sqlt_pkg::M_SLASHSTAR; len_in = grown1;
               end else redo = 1'b1;
            end
            sqlt_pkg::M_SLASHSTAR: begin
               cls_in  = sqlt_pkg::C_SPACE;
               len_in  = grown1;
               mode_in = (text_byte == sqlt_pkg::CH_STAR) ? sqlt_pkg::M_BLKSTAR :
                         sqlt_pkg::M_BLK;
            end
            sqlt_pkg::M_BLK: begin
               len_in = grown1;
               if (text_byte == sqlt_pkg::CH_STAR) mode_in = sqlt_pkg::M_BLKSTAR;
            end
            sqlt_pkg::M_BLKSTAR: begin
               len_in = grown1;
               if (text_byte == sqlt_pkg::CH_SLASH) begin
                  tok_class[cnt] = cls_ff; tok_start[cnt] = start_ff;
                  tok_length[cnt] = grown1; cnt = cnt + 2'd1;
                  mode_in = sqlt_pkg::M_IDLE;
               end else if (text_byte != sqlt_pkg::CH_STAR) mode_in = sqlt_pkg::M_BLK;
            end
            sqlt_pkg::M_EQ1: begin
               if (text_byte == sqlt_pkg::CH_EQ) begin
                  tok_class[cnt] = cls_ff; tok_start[cnt] = start_ff;
                  tok_length[cnt] = grown1; cnt = cnt + 2'd1;
                  mode_in = sqlt_pkg::M_IDLE;
               end else redo = 1'b1;
            end
            sqlt_pkg::M_LT1: begin
               if (text_byte == sqlt_pkg::CH_EQ || text_byte == sqlt_pkg::CH_GT ||
                   text_byte == sqlt_pkg::CH_LT) begin
                  tok_class[cnt] = (text_byte == sqlt_pkg::CH_EQ) ? sqlt_pkg::C_LE :
                                   (text_byte == sqlt_pkg::CH_GT) ? sqlt_pkg::C_NE :
                                   sqlt_pkg::C_LSHIFT;
                  tok_start[cnt] = start_ff; tok_length[cnt] = grown1; cnt = cnt + 2'd1;
                  mode_in = sqlt_pkg::M_IDLE;
               end else redo = 1'b1;
            end
            sqlt_pkg::M_GT1: begin
               if (text_byte == sqlt_pkg::CH_EQ || text_byte == sqlt_pkg::CH_GT) begin
                  tok_class[cnt] = (text_byte == sqlt_pkg::CH_EQ) ? sqlt_pkg::C_GE :
                                   sqlt_pkg::C_RSHIFT;
                  tok_start[cnt] = start_ff; tok_length[cnt] = grown1; cnt = cnt + 2'd1;
                  mode_in = sqlt_pkg::M_IDLE;
               end else redo = 1'b1;
            end
            sqlt_pkg::M_BANG1: begin
               // the byte after a bang is swallowed unless it ends the text
               tok_class[cnt] = (text_byte == sqlt_pkg::CH_EQ) ? sqlt_pkg::C_NE :
                                sqlt_pkg::C_ILLEGAL;
               tok_start[cnt] = start_ff; tok_length[cnt] = grown1; cnt = cnt + 2'd1;
               mode_in = sqlt_pkg::M_IDLE;
            end
            sqlt_pkg::M_BAR1: begin
               if (text_byte == sqlt_pkg::CH_BAR) begin
                  tok_class[cnt] = sqlt_pkg::C_CONCAT; tok_start[cnt] = start_ff;
                  tok_length[cnt] = grown1; cnt = cnt + 2'd1;
                  mode_in = sqlt_pkg::M_IDLE;
               end else redo = 1'b1;
            end
            sqlt_pkg::M_QUOTE: begin
               len_in = grown1;
               if (text_byte == delim_ff) mode_in = sqlt_pkg::M_QDELIM;
               else if (!sqlt_pkg::is_ident(text_byte)) aci_in = 1'b0;
            end
            sqlt_pkg::M_QDELIM: begin
               if (text_byte == delim_ff) begin
                  len_in = grown1; mode_in = sqlt_pkg::M_QUOTE;
               end else begin
                  cls_in = qclass; redo = 1'b1;
               end
            end
            sqlt_pkg::M_DOT1: begin
               if (sqlt_pkg::is_digit(text_byte)) begin
                  mode_in = sqlt_pkg::M_FRAC; cls_in = sqlt_pkg::C_FLOAT; len_in = grown1;
               end else redo = 1'b1;
            end
            sqlt_pkg::M_INT, sqlt_pkg::M_FRAC: begin
               if (sqlt_pkg::is_digit(text_byte)) len_in = grown1;
               else if (text_byte == sqlt_pkg::CH_DOT && mode_ff == sqlt_pkg::M_INT) begin
                  mode_in = sqlt_pkg::M_FRAC; cls_in = sqlt_pkg::C_FLOAT; len_in = grown1;
               end else if (text_byte == sqlt_pkg::CH_LOWE || text_byte == sqlt_pkg::CH_UPE)
               begin
                  mode_in = sqlt_pkg::M_EXPE; len_in = grown1;
               end else if (sqlt_pkg::is_ident(text_byte)) begin
                  mode_in = sqlt_pkg::M_ILLRUN; cls_in = sqlt_pkg::C_ILLEGAL;
                  len_in = grown1;
               end else redo = 1'b1;
            end
            sqlt_pkg::M_EXPE: begin
               if (sqlt_pkg::is_digit(text_byte)) begin
                  mode_in = sqlt_pkg::M_EXPDIG; cls_in = sqlt_pkg::C_FLOAT;
                  len_in = grown1;
               end else if (text_byte == sqlt_pkg::CH_PLUS ||
                            text_byte == sqlt_pkg::CH_MINUS) begin
                  mode_in  = sqlt_pkg::M_EXPSIGN;
                  minus_in = (text_byte == sqlt_pkg::CH_MINUS);
               end else begin
                  cls_in = sqlt_pkg::C_ILLEGAL;
                  if (sqlt_pkg::is_ident(text_byte)) begin
                     mode_in = sqlt_pkg::M_ILLRUN; len_in = grown1;
                  end else redo = 1'b1;
               end
            end
            sqlt_pkg::M_EXPSIGN: begin
               if (sqlt_pkg::is_digit(text_byte)) begin
                  mode_in = sqlt_pkg::M_EXPDIG; cls_in = sqlt_pkg::C_FLOAT;
                  len_in = grown2;
               end else begin
                  // failed exponent, then the held sign is scanned again
                  tok_class[cnt] = sqlt_pkg::C_ILLEGAL; tok_start[cnt] = start_ff;
                  tok_length[cnt] = len_ff; cnt = cnt + 2'd1;
                  if (minus_ff && text_byte == sqlt_pkg::CH_MINUS) begin
                     mode_in  = sqlt_pkg::M_LINECMT;
                     cls_in   = sqlt_pkg::C_SPACE;
                     start_in = pos_m1;
                     len_in   = {{(LENGTH_BITS-2){1'b0}}, 2'd2};
                  end else begin
                     tok_class[cnt] = minus_ff ? sqlt_pkg::C_MINUS : sqlt_pkg::C_PLUS;
                     tok_start[cnt] = pos_m1;
                     tok_length[cnt] = {{(LENGTH_BITS-1){1'b0}}, 1'b1}; cnt = cnt + 2'd1;
                     mode_in = sqlt_pkg::M_IDLE;
                     redo = 1'b1;
                  end
               end
            end
            sqlt_pkg::M_EXPDIG: begin
               if (sqlt_pkg::is_digit(text_byte)) len_in = grown1;
               else if (sqlt_pkg::is_ident(text_byte)) begin
                  mode_in = sqlt_pkg::M_ILLRUN; cls_in = sqlt_pkg::C_ILLEGAL;
                  len_in = grown1;
               end else redo = 1'b1;
            end
            sqlt_pkg::M_ILLRUN: begin
               if (sqlt_pkg::is_ident(text_byte)) len_in = grown1;
               else redo = 1'b1;
            end
            sqlt_pkg::M_BLOBE, sqlt_pkg::M_BLOBO: begin
               len_in = grown1;
               if (text_byte == sqlt_pkg::CH_SQUOTE) begin
                  tok_class[cnt] = (mode_ff == sqlt_pkg::M_BLOBO) ? sqlt_pkg::C_ILLEGAL :
                                   cls_ff;
                  tok_start[cnt] = start_ff; tok_length[cnt] = grown1; cnt = cnt + 2'd1;
                  mode_in = sqlt_pkg::M_IDLE;
               end else begin
                  if (!sqlt_pkg::is_hex(text_byte)) cls_in = sqlt_pkg::C_ILLEGAL;
                  mode_in = (mode_ff == sqlt_pkg::M_BLOBE) ? sqlt_pkg::M_BLOBO :
                            sqlt_pkg::M_BLOBE;
               end
            end
            default: begin
               mode_in = sqlt_pkg::M_IDLE;
               redo = 1'b1;
            end
         endcase

         // flush the pending token (unless idle) and start again on this byte
         if (redo) begin
            if (eff_mode != sqlt_pkg::M_IDLE && eff_mode != sqlt_pkg::M_EXPSIGN &&
                mode_ff <= sqlt_pkg::M_BLOBO) begin
               tok_class[cnt] = cls_in; tok_start[cnt] = start_ff;
               tok_length[cnt] = len_ff; cnt = cnt + 2'd1;
            end
            mode_in = sqlt_pkg::M_IDLE;
            if (bg.emit) begin
               tok_class[cnt] = bg.cls; tok_start[cnt] = pos_ff;
               tok_length[cnt] = {{(LENGTH_BITS-1){1'b0}}, 1'b1}; cnt = cnt + 2'd1;
            end else begin
               mode_in  = bg.mode;
               cls_in   = bg.cls;
               start_in = pos_ff;
               len_in   = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
               if (bg.quote) begin
                  delim_in = text_byte;
                  aci_in   = 1'b1;
               end
            end
         end
      end
      tok_count = cnt;
   end

   // Scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sqlt_pkg::M_IDLE;
         cls_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         minus_ff <= 1'b0;
         delim_ff <= '0;
         aci_ff   <= 1'b1;
         pos_ff   <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         cls_ff   <= cls_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         minus_ff <= minus_in;
         delim_ff <= delim_in;
         aci_ff   <= aci_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// ----- design/sqlt_out.sv -----
// Result stage: holds the tokens of one step and hands them out in order
module sqlt_out #(
   parameter int LENGTH_BITS   = sqlt_pkg::LENGTH_BITS_DEF,
   parameter int POSITION_BITS = sqlt_pkg::POSITION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic [4:0]               tok_class [sqlt_pkg::MAX_TOKENS],
   input  logic [POSITION_BITS-1:0] tok_start [sqlt_pkg::MAX_TOKENS],
   input  logic [LENGTH_BITS-1:0]   tok_length [sqlt_pkg::MAX_TOKENS],
   input  logic [sqlt_pkg::TOKEN_IDX_BITS-1:0] tok_count,
   output sqlt_pkg::stage_type      status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [4:0]               rsp_token_class,
   output logic [31:0]              rsp_token_start,
   output logic [LENGTH_BITS-1:0]   rsp_token_length,
   output logic                     rsp_last_of_run
);

   logic [4:0]               cls_ff [sqlt_pkg::MAX_TOKENS];
   logic [POSITION_BITS-1:0] start_ff [sqlt_pkg::MAX_TOKENS];
   logic [LENGTH_BITS-1:0]   len_ff [sqlt_pkg::MAX_TOKENS];
   logic [sqlt_pkg::TOKEN_IDX_BITS-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic                     pop, last;
   logic [POSITION_BITS+31:0] start_wide;

   assign rsp_valid = (cnt_ff != '0);
   assign last      = (idx_ff == cnt_ff - 2'd1);
   assign pop       = rsp_valid && !rsp_stall;
   assign status.valid = rsp_valid;
   assign status.free  = !rsp_valid || (pop && last);

   assign start_wide       = {32'd0, start_ff[idx_ff]};
   assign rsp_token_class  = cls_ff[idx_ff];
   assign rsp_token_start  = start_wide[31:0];
   assign rsp_token_length = len_ff[idx_ff];
   assign rsp_last_of_run  = last;

   // Count and read pointer
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load && status.free) begin
         cnt_in = tok_count;
         idx_in = '0;
      end else if (pop) begin
         if (last) cnt_in = '0;
         else idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // Token payload
   always_ff @(posedge clock) begin
      if (load && status.free) begin
         cls_ff   <= tok_class;
         start_ff <= tok_start;
         len_ff   <= tok_length;
      end
   end

endmodule

// ----- design/sql_query_tokenizer.sv -----
// SQL query tokenizer, one text byte per transaction.
// Request channel: req_text_byte with req_end_of_text; a zero byte or the end
// flag ends the text, flushes the pending token and adds an END token.
// Response channel: one token per transaction (class, start offset, length),
// rsp_last_of_run marks the last token caused by one request.
// A request is held in an input register, scanned, and its tokens (zero to
// three) land in the result register. Requests are taken one per cycle
// while req_stall is low; a request that yields several tokens holds the
// result register until each of them is taken, and the next request waits
// in the input register meanwhile.
// While the receiver stalls, the result register holds its token and one
// more request is taken into the input register; after that req_stall rises.
// Synchronous reset returns the scanner to idle between tokens, clears the
// byte offset and drops any pending request or token.
`include "sql_query_tokenizer_macros.svh"
module sql_query_tokenizer #(
   parameter int LENGTH_BITS   = sqlt_pkg::LENGTH_BITS_DEF,
   parameter int POSITION_BITS = sqlt_pkg::POSITION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_end_of_text,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [4:0]             rsp_token_class,
   output logic [31:0]            rsp_token_start,
   output logic [LENGTH_BITS-1:0] rsp_token_length,
   output logic                   rsp_last_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;
   logic       step;
   sqlt_pkg::stage_type status;

   logic [4:0]               tok_class [sqlt_pkg::MAX_TOKENS];
   logic [POSITION_BITS-1:0] tok_start [sqlt_pkg::MAX_TOKENS];
   logic [LENGTH_BITS-1:0]   tok_length [sqlt_pkg::MAX_TOKENS];
   logic [sqlt_pkg::TOKEN_IDX_BITS-1:0] tok_count;

   // Input register
   assign step      = in_valid_ff && status.free;
   assign req_stall = in_valid_ff && !status.free;
   assign in_valid_in = (req_valid && !req_stall) ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_text_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   sqlt_scan #(.LENGTH_BITS(LENGTH_BITS), .POSITION_BITS(POSITION_BITS)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .text_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .tok_class   (tok_class),
      .tok_start   (tok_start),
      .tok_length  (tok_length),
      .tok_count   (tok_count)
   );

   sqlt_out #(.LENGTH_BITS(LENGTH_BITS), .POSITION_BITS(POSITION_BITS)) u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (step),
      .tok_class        (tok_class),
      .tok_start        (tok_start),
      .tok_length       (tok_length),
      .tok_count        (tok_count),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_class  (rsp_token_class),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // a stalled token blocks the scan of the held request
   `SQLT_ASSERT_NOW(a_hold_on_stall, clock, reset, in_valid_ff && status.valid && rsp_stall, req_stall)
   // end marker has zero length and closes its run
   `SQLT_ASSERT_NOW(a_end_marker, clock, reset, rsp_valid && rsp_token_class == sqlt_pkg::C_END, rsp_token_length == '0 && rsp_last_of_run)
   // end of text always yields a token next cycle
   `SQLT_ASSERT_NEXT(a_end_emits, clock, reset, step && (in_eot_ff || in_byte_ff == sqlt_pkg::CH_NUL), rsp_valid)

endmodule
